// File: sv/bgns_pkg.sv
package bgns_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 256;

    localparam int CFG_W   = 9;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int DIM_MIN = 3;

    localparam logic [CFG_W-1:0] DIM_RESET = 9'd32;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    localparam logic MODE_SMOOTH   = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic [3:0] SMOOTH_LO = 4'd2;
    localparam logic [3:0] SMOOTH_HI = 4'd6;

    localparam logic [1:0] VAL_EMPTY = 2'd0;
    localparam logic [1:0] VAL_WALL  = 2'd1;
    localparam logic [1:0] VAL_FLOOR = 2'd2;

    typedef struct packed {
        logic cell_in;
        logic pad_item;
    } cell_t;

    typedef struct packed {
        logic [1:0] cell_value;
        logic [7:0] out_row;
        logic [7:0] out_col;
        logic       frame_last;
    } stencil_out_t;

    typedef struct packed {
        logic [8:0] win;
        logic       border;
        logic [7:0] row;
        logic [7:0] col;
        logic       last;
    } stage_t;

endpackage

// File: sv/binary_grid_neighbour_stencil.sv
// 3x3 neighbourhood pass over a binary grid streamed in raster order. One cell
// transfer is taken per cycle, back to back, unless stalled; a cell's result passes
// the window and rule registers after the transfer completing its neighbourhood, the
// cell one line and one place later. After the last grid cell send grid_cols+1 pad
// transfers to flush the final row. Two lines of history live in one 2-bit wide
// memory of MAX_COLS words, read each cycle, written per accepted transfer. Writing
// grid_rows or grid_cols restarts the frame; configure only while the block is idle.
module binary_grid_neighbour_stencil #(
    parameter int MAX_COLS = bgns_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = bgns_pkg::MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgns_pkg::ADDR_W-1:0] paddr,
    input  logic [bgns_pkg::DATA_W-1:0] pwdata,
    output logic [bgns_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        cell_valid,
    output logic                        cell_stall,
    input  bgns_pkg::cell_t             cell_data,
    output logic                        result_valid,
    input  logic                        result_stall,
    output bgns_pkg::stencil_out_t      result_data
);
    import bgns_pkg::*;

    localparam int CDW = $clog2(MAX_COLS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 2);

    logic [RW-1:0]  rows;
    logic [CDW-1:0] cols;
    logic           mode;
    logic           restart;
    logic           acc;
    logic           bit_in;
    logic [1:0]     taps;
    logic           s1_valid;
    logic           s1_ready;
    stage_t         s1_data;

    // pad transfers enter the history as clear cells
    assign bit_in = cell_data.cell_in && !cell_data.pad_item;

    bgns_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CDW      (CDW),
        .RW       (RW)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows),
        .cols    (cols),
        .mode    (mode),
        .restart (restart)
    );

    bgns_linebuf #(
        .MAX_COLS (MAX_COLS),
        .CDW      (CDW)
    ) u_linebuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .restart (restart),
        .cols    (cols),
        .bit_in  (bit_in),
        .taps    (taps)
    );

    bgns_window #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CDW      (CDW),
        .RW       (RW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows       (rows),
        .cols       (cols),
        .restart    (restart),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .bit_in     (bit_in),
        .taps       (taps),
        .acc        (acc),
        .s1_ready   (s1_ready),
        .s1_valid   (s1_valid),
        .s1_data    (s1_data)
    );

    bgns_rule u_rule (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .s1_valid     (s1_valid),
        .s1_data      (s1_data),
        .s1_ready     (s1_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// File: sv/bgns_cfg.sv
module bgns_cfg #(
    parameter int MAX_COLS = bgns_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = bgns_pkg::MAX_ROWS_DEF,
    parameter int CDW      = $clog2(MAX_COLS + 1),
    parameter int RW       = $clog2(MAX_ROWS + 2)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bgns_pkg::ADDR_W-1:0] paddr,
    input  logic [bgns_pkg::DATA_W-1:0] pwdata,
    output logic [bgns_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output logic [RW-1:0]               rows,
    output logic [CDW-1:0]              cols,
    output logic                        mode,
    output logic                        restart
);
    import bgns_pkg::*;

    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;
    logic             pass_mode_reg;
    logic             wr;
    logic [1:0]       idx;
    int               r_int;
    int               c_int;

    assign idx     = paddr[ADDR_W-1:2];
    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign restart = wr && (idx == REG_ROWS || idx == REG_COLS);
    assign mode    = pass_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DIM_RESET;
            grid_cols_reg <= DIM_RESET;
            pass_mode_reg <= MODE_SMOOTH;
        end
        else if (wr)
        begin
            case (idx)
                REG_ROWS: grid_rows_reg <= pwdata[CFG_W-1:0];
                REG_COLS: grid_cols_reg <= pwdata[CFG_W-1:0];
                REG_MODE: pass_mode_reg <= pwdata[0];
                default:  ;
            endcase
        end
    end

    // saturate dimensions to the supported range
    always_comb
    begin
        r_int = int'(grid_rows_reg);
        c_int = int'(grid_cols_reg);
        if (r_int < DIM_MIN)
            r_int = DIM_MIN;
        else if (r_int > MAX_ROWS)
            r_int = MAX_ROWS;
        if (c_int < DIM_MIN)
            c_int = DIM_MIN;
        else if (c_int > MAX_COLS)
            c_int = MAX_COLS;
        rows = RW'(r_int);
        cols = CDW'(c_int);
    end

    always_comb
    begin
        case (idx)
            REG_ROWS: prdata = DATA_W'(grid_rows_reg);
            REG_COLS: prdata = DATA_W'(grid_cols_reg);
            REG_MODE: prdata = DATA_W'(pass_mode_reg);
            default:  prdata = '0;
        endcase
    end

endmodule

// File: sv/bgns_linebuf.sv
module bgns_linebuf #(
    parameter int MAX_COLS = bgns_pkg::MAX_COLS_DEF,
    parameter int CDW      = $clog2(MAX_COLS + 1),
    parameter int PW       = $clog2(MAX_COLS)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           acc,
    input  logic           restart,
    input  logic [CDW-1:0] cols,
    input  logic           bit_in,
    output logic [1:0]     taps
);
    logic [1:0]    mem [MAX_COLS];
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [1:0]    rd_reg;

    assign taps = rd_reg;

    // circular delay of cols transfers; word holds one and two lines back
    always_comb
    begin
        ptr_next = ptr_reg;
        if (restart)
            ptr_next = '0;
        else if (acc)
        begin
            if (CDW'(ptr_reg) == cols - CDW'(1))
                ptr_next = '0;
            else
                ptr_next = ptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= '0;
        else
            ptr_reg <= ptr_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            mem[ptr_reg] <= {rd_reg[0], bit_in};
        rd_reg <= mem[ptr_next];
    end

endmodule

// File: sv/bgns_window.sv
module bgns_window #(
    parameter int MAX_COLS = bgns_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = bgns_pkg::MAX_ROWS_DEF,
    parameter int CDW      = $clog2(MAX_COLS + 1),
    parameter int RW       = $clog2(MAX_ROWS + 2)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RW-1:0]    rows,
    input  logic [CDW-1:0]   cols,
    input  logic             restart,
    input  logic             cell_valid,
    output logic             cell_stall,
    input  logic             bit_in,
    input  logic [1:0]       taps,
    output logic             acc,
    input  logic             s1_ready,
    output logic             s1_valid,
    output bgns_pkg::stage_t s1_data
);
    import bgns_pkg::*;

    logic [CDW-1:0] kc_reg;
    logic [RW-1:0]  kr_reg;
    logic [1:0]     tap_reg [3];
    logic           s1_valid_reg;
    stage_t         s1_data_reg;
    logic           emit;
    logic           last;
    logic [RW-1:0]  r;
    logic [CDW-1:0] c;
    logic           top;
    logic           bot;
    logic           left;
    logic           right;
    logic [2:0]     tap0;
    logic [8:0]     win;
    stage_t         s1_in;

    assign cell_stall = s1_valid_reg && !s1_ready;
    assign acc        = cell_valid && !cell_stall;
    assign s1_valid   = s1_valid_reg;
    assign s1_data    = s1_data_reg;

    // kr/kc: raster position of the incoming transfer, flush rows included
    assign last = (kr_reg == rows + RW'(1)) && (kc_reg == '0);
    assign emit = (kr_reg != '0) && !((kr_reg == RW'(1)) && (kc_reg == '0));

    // centre cell sits one line and one cell behind
    always_comb
    begin
        if (kc_reg == '0)
        begin
            r = kr_reg - RW'(2);
            c = cols - CDW'(1);
        end
        else
        begin
            r = kr_reg - RW'(1);
            c = kc_reg - CDW'(1);
        end
        top   = (r == '0);
        bot   = (r == rows - RW'(1));
        left  = (c == '0);
        right = (c == cols - CDW'(1));
    end

    assign tap0 = {taps[1], taps[0], bit_in};

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic b;
                b = (j == 0) ? tap0[l] : tap_reg[l][j-1];
                if ((l == 2 && top) || (l == 0 && bot) || (j == 2 && left) || (j == 0 && right))
                    b = 1'b0;
                win[(2 - l) * 3 + (2 - j)] = b;
            end
        end
    end

    always_comb
    begin
        s1_in.win    = win;
        s1_in.border = top || bot || left || right;
        s1_in.row    = 8'(r);
        s1_in.col    = 8'(c);
        s1_in.last   = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg       <= '0;
            kr_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                kc_reg <= '0;
                kr_reg <= '0;
            end
            else if (acc)
            begin
                if (last)
                begin
                    kc_reg <= '0;
                    kr_reg <= '0;
                end
                else if (kc_reg == cols - CDW'(1))
                begin
                    kc_reg <= '0;
                    kr_reg <= kr_reg + RW'(1);
                end
                else
                    kc_reg <= kc_reg + CDW'(1);
            end
            if (acc && emit)
                s1_valid_reg <= 1'b1;
            else if (s1_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int l = 0; l < 3; l++)
            begin
                tap_reg[l][0] <= tap0[l];
                tap_reg[l][1] <= tap_reg[l][0];
            end
        end
        if (acc && emit)
            s1_data_reg <= s1_in;
    end

endmodule

// File: sv/bgns_rule.sv
module bgns_rule (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mode,
    input  logic                   s1_valid,
    input  bgns_pkg::stage_t       s1_data,
    output logic                   s1_ready,
    output logic                   result_valid,
    input  logic                   result_stall,
    output bgns_pkg::stencil_out_t result_data
);
    import bgns_pkg::*;

    logic         out_valid_reg;
    stencil_out_t out_data_reg;
    logic [3:0]   count;
    logic [1:0]   value;
    stencil_out_t res;

    assign s1_ready     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                count = count + 4'(s1_data.win[i]);
        end
    end

    always_comb
    begin
        case (mode)
            MODE_SMOOTH:
            begin
                if (!s1_data.border && count > SMOOTH_LO && count < SMOOTH_HI)
                    value = 2'd1;
                else
                    value = 2'd0;
            end
            MODE_CLASSIFY:
            begin
                if (s1_data.win[4])
                    value = VAL_FLOOR;
                else if (count != '0)
                    value = VAL_WALL;
                else
                    value = VAL_EMPTY;
            end
            default: value = VAL_EMPTY;
        endcase
        res.cell_value = value;
        res.out_row    = s1_data.row;
        res.out_col    = s1_data.col;
        res.frame_last = s1_data.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_ready)
            out_valid_reg <= s1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
            out_data_reg <= res;
    end

endmodule

// File: tb/sv/tb_binary_grid_neighbour_stencil.sv
`timescale 1ns / 1ps

module tb_binary_grid_neighbour_stencil;

    import bgns_pkg::*;

    localparam int STORE_LEN = 2 * MAX_COLS_DEF + 3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 8;

    class stencil_scoreboard;
        logic [STORE_LEN-1:0] history;
        int unsigned frame_pos;
        logic [CFG_W-1:0] rows_reg;
        logic [CFG_W-1:0] cols_reg;
        logic mode_reg;
        stencil_out_t expected_cells[$];
        int mismatches;

        function new();
            history = '0;
            frame_pos = 0;
            rows_reg = DIM_RESET;
            cols_reg = DIM_RESET;
            mode_reg = MODE_SMOOTH;
            mismatches = 0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
            if (v < DIM_MIN)
                return DIM_MIN;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned eff_rows();
            return clamp_dim(rows_reg, MAX_ROWS_DEF);
        endfunction

        function int unsigned eff_cols();
            return clamp_dim(cols_reg, MAX_COLS_DEF);
        endfunction

        function int unsigned grid_cells();
            return eff_rows() * eff_cols();
        endfunction

        function int unsigned frame_len();
            return grid_cells() + eff_cols() + 1;
        endfunction

        function int unsigned next_index();
            return (frame_pos >= frame_len()) ? 0 : frame_pos;
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        function void write_reg(logic [1:0] idx, int unsigned value);
            case (idx)
                REG_ROWS:
                begin
                    rows_reg = value[CFG_W-1:0];
                    frame_pos = 0;
                end
                REG_COLS:
                begin
                    cols_reg = value[CFG_W-1:0];
                    frame_pos = 0;
                end
                REG_MODE: mode_reg = value[0];
                default: ;
            endcase
        endfunction

        function void note_cell(cell_t c);
            int unsigned rows, cols, cells, k, o, r, col, cnt;
            int off;
            logic fresh;
            logic in_grid;
            logic [8:0] win;
            stencil_out_t res;
            rows = eff_rows();
            cols = eff_cols();
            cells = rows * cols;
            k = next_index();
            fresh = c.pad_item ? 1'b0 : c.cell_in;
            history = {history[STORE_LEN-2:0], fresh};
            frame_pos = (k + 1 >= frame_len()) ? 0 : k + 1;
            if (k < cols + 1)
                return;
            o = k - cols - 1;
            if (o >= cells)
                return;
            r = o / cols;
            col = o % cols;
            win = '0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    in_grid = 1'b1;
                    if (dr < 0 && r == 0)
                        in_grid = 1'b0;
                    if (dr > 0 && r + 1 >= rows)
                        in_grid = 1'b0;
                    if (dc < 0 && col == 0)
                        in_grid = 1'b0;
                    if (dc > 0 && col + 1 >= cols)
                        in_grid = 1'b0;
                    off = int'(cols) + 1 - dr * int'(cols) - dc;
                    if (in_grid)
                        win[(dr + 1) * 3 + (dc + 1)] = history[off];
                end
            end
            cnt = 0;
            for (int i = 0; i < 9; i++)
                if (i != 4)
                    cnt += win[i];
            if (mode_reg == MODE_SMOOTH)
            begin
                if (r == 0 || r + 1 == rows || col == 0 || col + 1 == cols)
                    res.cell_value = VAL_EMPTY;
                else
                    res.cell_value = {1'b0, (cnt > SMOOTH_LO && cnt < SMOOTH_HI)};
            end
            else if (win[4])
                res.cell_value = VAL_FLOOR;
            else
                res.cell_value = (cnt != 0) ? VAL_WALL : VAL_EMPTY;
            res.out_row = r[7:0];
            res.out_col = col[7:0];
            res.frame_last = (o + 1 == cells);
            expected_cells.push_back(res);
        endfunction

        function void check_result(stencil_out_t got);
            stencil_out_t exp;
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value=%0d row=%0d col=%0d last=%0d",
                             got.cell_value, got.out_row, got.out_col, got.frame_last);
                return;
            end
            exp = expected_cells.pop_front();
            if (got.cell_value !== exp.cell_value || got.out_row !== exp.out_row ||
                got.out_col !== exp.out_col || got.frame_last !== exp.frame_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("mismatch: exp value=%0d row=%0d col=%0d last=%0d, ",
                           exp.cell_value, exp.out_row, exp.out_col, exp.frame_last);
                    $display("got value=%0d row=%0d col=%0d last=%0d",
                             got.cell_value, got.out_row, got.out_col, got.frame_last);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic cell_valid = 1'b0;
    logic cell_stall;
    cell_t cell_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    stencil_out_t result_data;

    stencil_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    binary_grid_neighbour_stencil uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cell_valid(cell_valid),
        .cell_stall(cell_stall),
        .cell_data(cell_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_cell(input logic cell_in, input logic pad_item);
        cell_t c;
        c.cell_in = cell_in;
        c.pad_item = pad_item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data <= c;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        sb.note_cell(c);
    endtask

    // drop valid, drain results, give the pipeline time to empty
    task automatic settle();
        cell_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_run(input int count);
        int dens;
        dens = $urandom_range(100);
        for (int n = 0; n < count; n++)
        begin
            if (sb.next_index() == 0)
                dens = $urandom_range(100);
            if (sb.next_index() < sb.grid_cells())
                send_cell($urandom_range(99) < dens, $urandom_range(49) == 0);
            else if ($urandom_range(7) == 0)
                send_cell(1'($urandom_range(1)), 1'b0);
            else
                send_cell(1'($urandom_range(1)), 1'b1);
        end
    endtask

    function automatic int unsigned pick_dim();
        if ($urandom_range(7) == 0)
            return $urandom_range(2);
        return $urandom_range(3, 10);
    endfunction

    task automatic run_phase(input int budget, input int unsigned big_rows,
                             input int unsigned big_cols);
        int sent, len, n, cut;
        settle();
        write_reg(REG_ROWS, big_rows);
        write_reg(REG_COLS, big_cols);
        write_reg(REG_MODE, $urandom_range(1));
        len = sb.frame_len();
        send_run(len);
        sent = len;
        while (sent < budget)
        begin
            settle();
            if ($urandom_range(3) != 0)
                write_reg(REG_ROWS, pick_dim());
            if ($urandom_range(3) != 0)
                write_reg(REG_COLS, pick_dim());
            if ($urandom_range(1) != 0)
                write_reg(REG_MODE, $urandom_range(1));
            len = sb.frame_len();
            n = $urandom_range(1, 3) * len - sb.next_index();
            // broken frame: stop part way through
            if ($urandom_range(4) == 0)
            begin
                cut = $urandom_range(1, len - 1);
                if (n > cut)
                    n = n - cut;
            end
            send_run(n);
            sent += n;
        end
    endtask

    initial
    begin
        logic [8:0] pat;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest grid, centre sent as a pad with cell_in high, a live cell in the flush
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 2);
        write_reg(REG_MODE, 32'(MODE_SMOOTH));
        pat = 9'b000_011_111;
        for (int i = 0; i < 9; i++)
            send_cell(pat[i], i == 4);
        send_cell(1'b1, 1'b0);
        repeat (3) send_cell(1'b1, 1'b1);

        settle();
        write_reg(REG_MODE, 32'(MODE_CLASSIFY));
        pat = 9'b100_000_000;
        for (int i = 0; i < 9; i++)
            send_cell(pat[i], 1'b0);
        repeat (4) send_cell(1'b0, 1'b1);

        send_idle_pct = 11;
        recv_stall_pct = 56;
        run_phase(1050, 0, 511);

        send_idle_pct = 56;
        recv_stall_pct = 11;
        run_phase(800, 511, 2);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_phase(100, 4, 7);

        settle();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
sv/bgns_pkg.sv
sv/bgns_cfg.sv
sv/bgns_linebuf.sv
sv/bgns_window.sv
sv/bgns_rule.sv
sv/binary_grid_neighbour_stencil.sv
tb/sv/tb_binary_grid_neighbour_stencil.sv
